/* hdl/cfr_pkg.sv */
// shared types and constants for the cobs frame receiver
`default_nettype none

package cfr_pkg;

   localparam int unsigned BYTE_W          = 8;
   localparam int unsigned LEN_W           = 7;
   localparam int unsigned STATUS_W        = 2;
   localparam int unsigned MAX_ENCODED_DEF = 128;
   localparam int unsigned QUEUE_DEPTH     = 2;

   localparam logic [BYTE_W-1:0] FULL_CODE        = 8'hFF;
   localparam logic [LEN_W-1:0]  COUNT_MAX        = 7'd127;
   localparam logic [LEN_W-1:0]  MIN_LENGTH_RESET = 7'd7;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FRAMING = 2'd1,
      STATUS_SHORT   = 2'd2
   } status_type;

   typedef enum logic {
      CMD_DATA = 1'b0,
      CMD_END  = 1'b1
   } cmd_kind_type;

   // one command from the front to the back
   typedef struct packed {
      cmd_kind_type      kind;
      logic [BYTE_W-1:0] data;
      logic              framing;
   } cmd_type;

endpackage

`default_nettype wire

/* hdl/cobs_frame_receiver.sv */
// top level of the cobs frame receiver
// Streaming COBS decoder. One line byte beat is taken per clock; a zero byte
// ends the frame. Each decoded data byte comes out as its own result beat,
// and a frame that took at least one non-zero byte ends with one status beat
// (rsp_is_end high) giving ok, framing error (last block cut short) or too
// short (fewer decoded bytes than the min length register), plus the decoded
// length, which saturates at 127. The implied zero of a short block is held
// until the next code byte arrives, so the trailing implied zero never shows.
// Non-zero bytes past MAX_ENCODED in one frame are dropped. Rate is one byte
// per cycle sustained; a result's valid rises once its command is in the
// output register (the command is written into the queue at the accepting
// edge and moves on into the output register once that is free). The front
// stalls only when the two-entry command queue is full, which happens only
// while the consumer holds rsp_stall. The min length register resets to 7
// and is written through csr_write_enable / csr_write_data.
`default_nettype none

module cobs_frame_receiver #(
   parameter int unsigned MAX_ENCODED = cfr_pkg::MAX_ENCODED_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // line byte input
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [cfr_pkg::BYTE_W-1:0]   req_in_byte,
   // decoded result output
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [cfr_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                              rsp_is_end,
   output logic [cfr_pkg::STATUS_W-1:0]      rsp_status,
   output logic [cfr_pkg::LEN_W-1:0]         rsp_frame_length,
   // min frame length register
   input  wire logic                         csr_write_enable,
   input  wire logic [cfr_pkg::LEN_W-1:0]    csr_write_data
);
   import cfr_pkg::*;

   logic    accept;
   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   // a beat is taken whenever the queue has a free slot
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // block tracking: code bytes, data bytes, held-back zeros, capacity
   cfr_front #(
      .MAX_ENCODED(MAX_ENCODED)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .push    (push),
      .cmd     (push_cmd)
   );

   // decouples byte intake from result delivery
   cfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // length count, status grading and output register
   cfr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .head_valid       (head_valid),
      .head_cmd         (head_cmd),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_is_end       (rsp_is_end),
      .rsp_status       (rsp_status),
      .rsp_frame_length (rsp_frame_length)
   );

endmodule

`default_nettype wire

/* hdl/cfr_front.sv */
// front end: accepts line bytes, tracks cobs blocks and issues commands
`default_nettype none

module cfr_front #(
   parameter int unsigned MAX_ENCODED = cfr_pkg::MAX_ENCODED_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic [cfr_pkg::BYTE_W-1:0] in_byte,
   output logic                            push,
   output cfr_pkg::cmd_type                cmd
);
   import cfr_pkg::*;

   localparam int unsigned ENC_W = $clog2(MAX_ENCODED + 1);
   localparam logic [ENC_W-1:0] ENC_LIMIT = ENC_W'(MAX_ENCODED);

   logic [ENC_W-1:0]  enc_count_ff, enc_count_in;
   logic [BYTE_W-1:0] remaining_ff, remaining_in;
   logic              full_block_ff, full_block_in;
   logic              zero_pending_ff, zero_pending_in;
   logic [BYTE_W-1:0] remaining_dec;

   assign remaining_dec = remaining_ff - BYTE_W'(1);

   always_comb begin
      enc_count_in    = enc_count_ff;
      remaining_in    = remaining_ff;
      full_block_in   = full_block_ff;
      zero_pending_in = zero_pending_ff;
      push            = 1'b0;
      cmd.kind        = CMD_DATA;
      cmd.data        = in_byte;
      cmd.framing     = 1'b0;
      if (accept) begin
         if (in_byte == '0) begin
            // delimiter: close the frame if anything was taken
            push            = (enc_count_ff != '0);
            cmd.kind        = CMD_END;
            cmd.data        = '0;
            cmd.framing     = (remaining_ff != '0);
            enc_count_in    = '0;
            remaining_in    = '0;
            full_block_in   = 1'b0;
            zero_pending_in = 1'b0;
         end else if (enc_count_ff < ENC_LIMIT) begin
            enc_count_in = enc_count_ff + ENC_W'(1);
            if (remaining_ff == '0) begin
               // code byte releases the held-back zero
               push            = zero_pending_ff;
               cmd.data        = '0;
               full_block_in   = (in_byte == FULL_CODE);
               remaining_in    = in_byte - BYTE_W'(1);
               zero_pending_in = (in_byte == BYTE_W'(1));
            end else begin
               push         = 1'b1;
               remaining_in = remaining_dec;
               if (remaining_dec == '0 && !full_block_ff) begin
                  zero_pending_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enc_count_ff    <= '0;
         remaining_ff    <= '0;
         full_block_ff   <= 1'b0;
         zero_pending_ff <= 1'b0;
      end else begin
         enc_count_ff    <= enc_count_in;
         remaining_ff    <= remaining_in;
         full_block_ff   <= full_block_in;
         zero_pending_ff <= zero_pending_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/cfr_queue.sv */
// short command queue between front and back
`default_nettype none

module cfr_queue (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire cfr_pkg::cmd_type push_cmd,
   output logic            full,
   input  wire logic       pop,
   output logic            head_valid,
   output cfr_pkg::cmd_type head_cmd
);
   import cfr_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/cfr_back.sv */
// back end: counts decoded bytes, grades frames, holds the result register
`default_nettype none

module cfr_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write_enable,
   input  wire logic [cfr_pkg::LEN_W-1:0]    csr_write_data,
   input  wire logic                         head_valid,
   input  wire cfr_pkg::cmd_type             head_cmd,
   output logic                              pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [cfr_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                              rsp_is_end,
   output logic [cfr_pkg::STATUS_W-1:0]      rsp_status,
   output logic [cfr_pkg::LEN_W-1:0]         rsp_frame_length
);
   import cfr_pkg::*;

   logic [LEN_W-1:0]  min_len_ff;
   logic [LEN_W-1:0]  decoded_ff, decoded_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              end_ff, end_in;
   status_type        status_ff, status_in;
   logic [LEN_W-1:0]  length_ff, length_in;

   assign pop = head_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      decoded_in = decoded_ff;
      valid_in   = valid_ff && rsp_stall;
      byte_in    = byte_ff;
      end_in     = end_ff;
      status_in  = status_ff;
      length_in  = length_ff;
      if (pop) begin
         valid_in = 1'b1;
         if (head_cmd.kind == CMD_END) begin
            byte_in   = '0;
            end_in    = 1'b1;
            length_in = decoded_ff;
            if (head_cmd.framing) begin
               status_in = STATUS_FRAMING;
            end else if (decoded_ff < min_len_ff) begin
               status_in = STATUS_SHORT;
            end else begin
               status_in = STATUS_OK;
            end
            decoded_in = '0;
         end else begin
            byte_in   = head_cmd.data;
            end_in    = 1'b0;
            status_in = STATUS_OK;
            length_in = '0;
            if (decoded_ff != COUNT_MAX) begin
               decoded_in = decoded_ff + LEN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= MIN_LENGTH_RESET;
         decoded_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            min_len_ff <= csr_write_data;
         end
         decoded_ff <= decoded_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      end_ff    <= end_in;
      status_ff <= status_in;
      length_ff <= length_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_is_end       = end_ff;
   assign rsp_status       = status_ff;
   assign rsp_frame_length = length_ff;

endmodule

`default_nettype wire

/* test/cobs_frame_receiver_tb.sv */
// testbench for the cobs frame receiver: directed and random cobs traffic, checked beat by beat
`timescale 1ns / 100ps

module cobs_frame_receiver_tb;

   import cfr_pkg::*;

   // encoded bytes the block accepts per frame (default build of the block)
   localparam int unsigned CAPACITY      = MAX_ENCODED_DEF;
   // pipeline is the command queue and the output register; this settle time covers any straggler
   localparam int unsigned SETTLE_CYCLES = 8;
   // receiver hold-off used to fill the command queue
   localparam int unsigned HOLD_OFF_LEN  = 300;
   // far above the slowest correct run of roughly 1700 bytes at 72 percent idling
   localparam int unsigned CYCLE_LIMIT   = 600000;
   // keep the log short when something goes badly wrong
   localparam int unsigned MAX_PRINTED   = 40;

   // one decoded beat as seen on the result port
   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic                is_end;
      status_type          status;
      logic [LEN_W-1:0]    frame_length;
   } decoded_beat_type;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_in_byte      = '0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic [BYTE_W-1:0]     rsp_out_byte;
   logic                  rsp_is_end;
   logic [STATUS_W-1:0]   rsp_status;
   logic [LEN_W-1:0]      rsp_frame_length;
   logic                  csr_write_enable = 1'b0;
   logic [LEN_W-1:0]      csr_write_data   = '0;

   // idling knobs, in percent
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;

   // long receiver hold-off, requested by a test and counted down by the stall process
   bit          hold_off_start = 1'b0;
   int unsigned hold_left      = 0;

   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned items_sent  = 0;

   // decoder state mirrored in the testbench
   logic [BYTE_W-1:0] enc_count;
   logic [BYTE_W-1:0] blk_left;
   logic [BYTE_W-1:0] blk_code;
   logic              zero_held;
   logic [LEN_W-1:0]  dec_count;
   logic [LEN_W-1:0]  min_length;

   // beats still owed by the block, oldest first
   decoded_beat_type expected_beats[$];

   // scratch frames: raw payload and its line encoding
   logic [BYTE_W-1:0] frame_data[$];
   logic [BYTE_W-1:0] line_bytes[$];

   cobs_frame_receiver DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_is_end       (rsp_is_end),
      .rsp_status       (rsp_status),
      .rsp_frame_length (rsp_frame_length),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // decoder prediction
   // ---------------------------------------------------------------------------

   function automatic void clear_frame_state();
      enc_count = '0;
      blk_left  = '0;
      blk_code  = '0;
      zero_held = 1'b0;
      dec_count = '0;
   endfunction

   // a decoded data byte; the length counter sticks at its top value
   function automatic void expect_data(input logic [BYTE_W-1:0] value);
      decoded_beat_type beat;
      beat.out_byte     = value;
      beat.is_end       = 1'b0;
      beat.status       = STATUS_OK;
      beat.frame_length = '0;
      expected_beats.push_back(beat);
      if (dec_count != COUNT_MAX)
         dec_count = dec_count + 1'b1;
   endfunction

   function automatic void decode_line_byte(input logic [BYTE_W-1:0] value);
      decoded_beat_type beat;
      if (value == 8'h00) begin
         // delimiter: status beat only when the frame took any byte
         if (enc_count != 0) begin
            beat.out_byte     = '0;
            beat.is_end       = 1'b1;
            // a cut-short block wins over the length check
            if (blk_left != 0)
               beat.status = STATUS_FRAMING;
            else if (dec_count < min_length)
               beat.status = STATUS_SHORT;
            else
               beat.status = STATUS_OK;
            beat.frame_length = dec_count;
            expected_beats.push_back(beat);
         end
         clear_frame_state();
      end else if (enc_count < CAPACITY) begin
         enc_count = enc_count + 1'b1;
         if (blk_left == 0) begin
            // code byte: the zero held from the last block is real now
            if (zero_held) begin
               zero_held = 1'b0;
               expect_data(8'h00);
            end
            blk_code = value;
            blk_left = value - 1'b1;
         end else begin
            expect_data(value);
            blk_left = blk_left - 1'b1;
         end
         // short block done: its implied zero waits for the next code byte
         if (blk_left == 0 && blk_code != FULL_CODE)
            zero_held = 1'b1;
      end
      // bytes past capacity are dropped without a trace
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] want_value,
                                  input logic [31:0] got_value);
      if (error_count < MAX_PRINTED)
         $display("%0t ns: mismatch on %s, expected %0h, got %0h", $time, field,
                  want_value, got_value);
      error_count++;
   endtask

   // ---------------------------------------------------------------------------
   // scoreboard: register writes, accepted line bytes and result beats are all
   // seen in this one process, so prediction and comparison keep a fixed order
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin
      decoded_beat_type want;
      if (reset) begin
         clear_frame_state();
         min_length = MIN_LENGTH_RESET;
         expected_beats.delete();
      end else begin
         if (csr_write_enable)
            min_length = csr_write_data;
         if (req_valid && !req_stall)
            decode_line_byte(req_in_byte);
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               report_mismatch("beat with none owed, out_byte", 32'h0, rsp_out_byte);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch("out_byte", want.out_byte, rsp_out_byte);
               if (rsp_is_end !== want.is_end)
                  report_mismatch("is_end", want.is_end, rsp_is_end);
               if (rsp_status !== want.status)
                  report_mismatch("status", want.status, rsp_status);
               if (rsp_frame_length !== want.frame_length)
                  report_mismatch("frame_length", want.frame_length, rsp_frame_length);
            end
         end
      end
   end

   // receiver side: random stalls, or a long hold-off when a test asks for one
   always @(posedge clock) begin
      if (hold_off_start) begin
         hold_off_start = 1'b0;
         hold_left      = HOLD_OFF_LEN;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // line side
   // ---------------------------------------------------------------------------

   // one line byte beat, with optional idle cycles in front of it
   task automatic send_line_byte(input logic [BYTE_W-1:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_in_byte <= value;
      do
         @(posedge clock);
      while (req_stall);
      items_sent++;
   endtask

   task automatic send_line();
      foreach (line_bytes[i])
         send_line_byte(line_bytes[i]);
   endtask

   // drop valid and wait until every owed beat is out, then let the pipe settle;
   // first wait for a clock edge so the scoreboard has seen the last accepted byte
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_length(input logic [LEN_W-1:0] value);
      wait_until_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // random payload, zero_pct percent of the bytes zero
   task automatic build_payload(input int unsigned length, input int unsigned zero_pct);
      logic [BYTE_W-1:0] value;
      frame_data.delete();
      repeat (length) begin
         value = BYTE_W'($urandom_range(255, 1));
         if ($urandom_range(99) < zero_pct)
            value = 8'h00;
         frame_data.push_back(value);
      end
   endtask

   // data, zero, data, zero ... data: every encoded byte after the first
   // yields one decoded byte, so 64 pairs fill capacity with 127 bytes out
   task automatic build_alternating(input int unsigned pairs);
      logic [BYTE_W-1:0] value;
      frame_data.delete();
      for (int unsigned i = 0; i < pairs; i++) begin
         value = BYTE_W'($urandom_range(255, 1));
         frame_data.push_back(value);
         if (i != pairs - 1)
            frame_data.push_back(8'h00);
      end
   endtask

   // standard cobs stuffing of frame_data into line_bytes, delimiter not included
   task automatic cobs_encode();
      int unsigned       code_at;
      logic [BYTE_W-1:0] run;
      line_bytes.delete();
      code_at = 0;
      line_bytes.push_back(8'h00);
      run = 8'd1;
      foreach (frame_data[i]) begin
         if (frame_data[i] == 8'h00) begin
            line_bytes[code_at] = run;
            code_at = line_bytes.size();
            line_bytes.push_back(8'h00);
            run = 8'd1;
         end else begin
            line_bytes.push_back(frame_data[i]);
            run = run + 8'd1;
            // full block: close it and open the next one
            if (run == FULL_CODE) begin
               line_bytes[code_at] = run;
               code_at = line_bytes.size();
               line_bytes.push_back(8'h00);
               run = 8'd1;
            end
         end
      end
      line_bytes[code_at] = run;
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // hand-made frames, checked against the reset value of the min length
   task automatic test_directed_frames();
      send_idle_pct = 0;
      stall_pct     = 0;
      line_bytes = '{
         8'h00,                                // empty frame, no status
         8'h01, 8'h00,                         // frame with no data bytes
         8'h02, 8'hFF, 8'h00,                  // one byte, trailing implied zero dropped
         8'h03, 8'h11, 8'h22, 8'h02, 8'h33, 8'h00,  // held zero released by next code
         8'h05, 8'hAA, 8'hBB, 8'h00,           // last block cut short
         8'hFF, 8'h01, 8'h80, 8'h00,           // full-size block cut short
         8'h01, 8'h01, 8'h01, 8'h00            // zeros only
      };
      send_line();
      wait_until_idle();
   endtask

   // min length at both ends of its range
   task automatic test_min_length_limits();
      // zero: even a frame with no data is ok
      write_min_length(7'd0);
      line_bytes = '{8'h01, 8'h00};
      send_line();
      repeat (3) begin
         build_payload($urandom_range(12), 30);
         cobs_encode();
         line_bytes.push_back(8'h00);
         send_line();
      end

      // top: only a frame of 127 decoded bytes passes
      write_min_length(7'd127);
      build_alternating(64);
      cobs_encode();
      line_bytes.push_back(8'h00);
      send_line();
      build_payload($urandom_range(1, 20), 20);
      cobs_encode();
      line_bytes.push_back(8'h00);
      send_line();
      wait_until_idle();
   endtask

   // mostly well-formed frames with random content, mixed with broken frames and noise
   task automatic test_random_traffic(input int unsigned idle_pct,
                                      input int unsigned busy_pct,
                                      input logic [LEN_W-1:0] min_len,
                                      input int unsigned count);
      int unsigned       goal;
      int unsigned       pick;
      int unsigned       pos;
      int unsigned       cut;
      logic [BYTE_W-1:0] value;
      write_min_length(min_len);
      send_idle_pct = idle_pct;
      stall_pct     = busy_pct;
      goal = items_sent + count;
      while (items_sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 85) begin
            // an occasional long frame runs into capacity
            if ($urandom_range(19) == 0)
               build_payload($urandom_range(140, 100), $urandom_range(40));
            else
               build_payload($urandom_range(24), $urandom_range(60));
            cobs_encode();
            if (pick >= 70) begin
               // damage the encoding
               case ($urandom_range(2))
                  0: begin
                     // drop the tail
                     if (line_bytes.size() > 1) begin
                        cut = $urandom_range(line_bytes.size() - 1, 1);
                        repeat (cut) line_bytes.delete(line_bytes.size() - 1);
                     end
                  end
                  1: begin
                     // overwrite any byte, code bytes included
                     pos = $urandom_range(line_bytes.size() - 1);
                     value = BYTE_W'($urandom_range(255, 1));
                     line_bytes[pos] = value;
                  end
                  default: begin
                     // early delimiter splits the frame
                     pos = $urandom_range(line_bytes.size());
                     line_bytes.insert(pos, 8'h00);
                  end
               endcase
            end
            line_bytes.push_back(8'h00);
         end else begin
            // raw line noise
            build_payload($urandom_range(16, 1), 12);
            line_bytes = frame_data;
         end
         send_line();
      end
      // close any frame the noise left open
      send_line_byte(8'h00);
      wait_until_idle();
   endtask

   // frames longer than the encoded capacity
   task automatic test_capacity_overrun();
      logic [BYTE_W-1:0] value;
      write_min_length(7'd10);
      send_idle_pct = 36;
      stall_pct     = 36;

      // exactly full, then extra bytes that must vanish
      build_alternating(64);
      cobs_encode();
      repeat (6) begin
         value = BYTE_W'($urandom_range(255, 1));
         line_bytes.push_back(value);
      end
      line_bytes.push_back(8'h00);
      send_line();

      // one huge block, longer than capacity, so it can never complete
      build_payload(200, 0);
      cobs_encode();
      line_bytes.push_back(8'h00);
      send_line();

      repeat (1) begin
         build_payload($urandom_range(250, 120), $urandom_range(30));
         cobs_encode();
         line_bytes.push_back(8'h00);
         send_line();
      end
      wait_until_idle();
   endtask

   // receiver holds off while bytes keep coming, so the block must stall its input
   task automatic test_output_backpressure();
      int unsigned goal;
      write_min_length(7'd4);
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_off_start = 1'b1;
      goal = items_sent + 80;
      while (items_sent < goal) begin
         build_payload($urandom_range(16, 4), 10);
         cobs_encode();
         line_bytes.push_back(8'h00);
         send_line();
      end
      wait_until_idle();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_frames();
      test_min_length_limits();
      // idling phases: none, sender, receiver, both
      test_random_traffic(0, 0, 7'd3, 200);
      test_random_traffic(72, 0, 7'($urandom_range(24)), 200);
      test_random_traffic(0, 72, 7'd12, 200);
      test_random_traffic(36, 36, 7'd1, 200);
      test_capacity_overrun();
      test_output_backpressure();

      wait_until_idle();
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
